// File: hdl/ctq_pkg.sv
package ctq_pkg;

    localparam int ID_W   = 11;
    localparam int LEN_W  = 4;
    localparam int DATA_W = 64;

    localparam logic [ID_W-1:0] MARKER_RST = 11'h7FF;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    typedef struct packed {
        logic              action;
        logic [ID_W-1:0]   frame_id;
        logic [LEN_W-1:0]  frame_len;
        logic [DATA_W-1:0] frame_bytes;
        logic              mailbox_free;
    } t_in;

    typedef struct packed {
        logic              push_rejected;
        logic              send_valid;
        logic [ID_W-1:0]   send_id;
        logic [LEN_W-1:0]  send_len;
        logic [DATA_W-1:0] send_bytes;
    } t_out;

    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] bytes;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // ring status seen by the scheduler
    typedef struct packed {
        logic full;
        logic empty;
    } t_ring;

    // update requests back to the pointer logic
    typedef struct packed {
        logic we;
        logic at_tail;
        logic adv_head;
        logic adv_tail;
    } t_upd;

endpackage

// File: hdl/ctq_ram.sv
module ctq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: hdl/ctq_sched.sv
module ctq_sched (
    input  ctq_pkg::t_in              i_item,
    input  ctq_pkg::t_entry           i_head,
    input  ctq_pkg::t_ring            i_ring,
    input  logic [ctq_pkg::ID_W-1:0]  i_marker,
    output ctq_pkg::t_upd             o_upd,
    output ctq_pkg::t_entry           o_wdata,
    output ctq_pkg::t_out             o_result
);

    ctq_pkg::t_entry dec_entry;
    logic            head_is_delay;
    logic            count_left;

    always_comb begin
        dec_entry            = i_head;
        dec_entry.bytes[7:0] = i_head.bytes[7:0] - 8'd1;
        head_is_delay        = (i_head.id == i_marker);
        count_left           = (i_head.bytes[7:0] > 8'd1);
    end

    always_comb begin
        o_upd    = '0;
        o_result = '0;
        o_wdata  = dec_entry;
        case (i_item.action)
            ctq_pkg::ACT_PUSH: begin
                o_wdata.id    = i_item.frame_id;
                o_wdata.len   = i_item.frame_len;
                o_wdata.bytes = i_item.frame_bytes;
                if (i_ring.full) begin
                    o_result.push_rejected = 1'b1;
                end else begin
                    o_upd.we       = 1'b1;
                    o_upd.at_tail  = 1'b1;
                    o_upd.adv_tail = 1'b1;
                end
            end
            ctq_pkg::ACT_TICK: begin
                if (!i_ring.empty) begin
                    if (head_is_delay) begin
                        // delay entry: count byte 0 down, drop it once spent
                        if (count_left) begin
                            o_upd.we = 1'b1;
                        end else begin
                            o_upd.adv_head = 1'b1;
                        end
                    end else if (i_item.mailbox_free) begin
                        o_result.send_valid = 1'b1;
                        o_result.send_id    = i_head.id;
                        o_result.send_len   = i_head.len;
                        o_result.send_bytes = i_head.bytes;
                        o_upd.adv_head      = 1'b1;
                    end
                end
            end
            default: begin
                o_upd = '0;
            end
        endcase
    end

endmodule

// File: hdl/can_tx_queue_with_delay_entries_top.sv
// Channel   Direction  Ports                    Accepted
// item      in         start, busy, i_item      edge with start high and busy low
// result    out        o_result_valid, o_result edge ending the strobe cycle
// config    in         i_cfg_we, i_cfg_wdata    edge with i_cfg_we high
//
// One item per cycle; the item is registered in r_in and the result in r_out,
// and the result strobe is high while r_out holds that item's result.
// The head entry is read from the ring RAM every cycle with the read address set
// to the next head, with a bypass for a write landing on that entry.
// busy never rises; reset clears pointers and strobes and restores the marker,
// the RAM is not cleared. Results cannot be stalled.
module can_tx_queue_with_delay_entries_top #(
    parameter int QUEUE_DEPTH = 32
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  ctq_pkg::t_in              i_item,
    output logic                      o_result_valid,
    output ctq_pkg::t_out             o_result,
    input  logic                      i_cfg_we,
    input  logic [ctq_pkg::ID_W-1:0]  i_cfg_wdata
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(QUEUE_DEPTH - 1);

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        logic [AW-1:0] n;
        n = (p == LAST) ? '0 : p + 1'b1;
        return n;
    endfunction

    ctq_pkg::t_in              r_in;
    logic                      r_in_v;
    logic [AW-1:0]             r_head;
    logic [AW-1:0]             r_tail;
    logic [AW-1:0]             n_head;
    logic [AW-1:0]             n_tail;
    logic [ctq_pkg::ID_W-1:0]  r_marker;
    logic                      r_byp_sel;
    ctq_pkg::t_entry           r_byp_data;
    logic                      r_out_v;
    ctq_pkg::t_out             r_out;

    logic [ctq_pkg::ENTRY_W-1:0] ram_rdata;
    ctq_pkg::t_entry             head_entry;
    ctq_pkg::t_entry             wdata;
    ctq_pkg::t_ring              ring;
    ctq_pkg::t_upd               upd;
    ctq_pkg::t_out               result;
    logic                        we;
    logic [AW-1:0]               waddr;

    assign busy = 1'b0;

    assign ring.empty = (r_head == r_tail);
    assign ring.full  = (f_inc(r_tail) == r_head);
    assign head_entry = r_byp_sel ? r_byp_data : ctq_pkg::t_entry'(ram_rdata);

    ctq_sched u_sched (
        .i_item   (r_in),
        .i_head   (head_entry),
        .i_ring   (ring),
        .i_marker (r_marker),
        .o_upd    (upd),
        .o_wdata  (wdata),
        .o_result (result)
    );

    always_comb begin
        we     = r_in_v & upd.we;
        waddr  = upd.at_tail ? r_tail : r_head;
        n_head = (r_in_v && upd.adv_head) ? f_inc(r_head) : r_head;
        n_tail = (r_in_v && upd.adv_tail) ? f_inc(r_tail) : r_tail;
    end

    ctq_ram #(
        .WIDTH (ctq_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (n_head),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v    <= 1'b0;
            r_head    <= '0;
            r_tail    <= '0;
            r_marker  <= ctq_pkg::MARKER_RST;
            r_byp_sel <= 1'b0;
            r_out_v   <= 1'b0;
        end else begin
            r_in_v    <= start & ~busy;
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_byp_sel <= we && (waddr == n_head);
            r_out_v   <= r_in_v;
            if (i_cfg_we) begin
                r_marker <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_in <= i_item;
        end
        r_byp_data <= wdata;
        r_out      <= result;
    end

    assign o_result_valid = r_out_v;
    assign o_result       = r_out;

endmodule
